// ----- rtl/core/sdspi_pkg.sv -----
// sdspi_pkg: shared types, constants and crc-7 helper for the spi-mode card responder
// no dependencies
package sdspi_pkg;

  localparam int unsigned SectorsDefault = 64;
  localparam int unsigned BlkBytes = 512;

  localparam logic [1:0] KindWrite = 2'd0;
  localparam logic [1:0] KindPeek = 2'd1;
  localparam logic [1:0] KindRead = 2'd2;
  localparam logic [1:0] KindStat = 2'd3;

  localparam logic [7:0] ByteToken = 8'hFE;
  localparam logic [7:0] ByteIdle = 8'hFF;
  localparam logic [7:0] ByteStatus = 8'hC0;
  localparam logic [7:0] OpMask = 8'h3F;
  localparam logic [7:0] R1Range = 8'h20;
  localparam logic [7:0] R1Crc = 8'h09;
  localparam logic [7:0] R1Accept = 8'h05;
  localparam logic [7:0] OpAcmd41 = 8'd105;
  localparam logic [7:0] OpCmd0 = 8'd0;
  localparam logic [7:0] OpCmd8 = 8'd8;
  localparam logic [7:0] OpCmd12 = 8'd12;
  localparam logic [7:0] OpCmd17 = 8'd17;
  localparam logic [7:0] OpCmd18 = 8'd18;
  localparam logic [7:0] OpCmd24 = 8'd24;
  localparam logic [7:0] OpCmd55 = 8'd55;
  localparam logic [7:0] OpCmd58 = 8'd58;

  localparam logic [1:0] CardSdv1 = 2'd0;
  localparam logic [1:0] CardSdhc = 2'd2;

  typedef enum logic [3:0] {
    PsIdle, PsR1, PsR3, PsR7, PsRdAck, PsRmAck, PsWrAck,
    PsRead, PsRmrd, PsRmnxt, PsWrWait, PsWrite
  } proto_e;

  // controller sequencing
  typedef enum logic [2:0] {
    CsClear, CsIdle, CsCopy, CsDone
  } ctrl_e;

  // copy direction
  typedef enum logic [1:0] {
    CpNone, CpFetch, CpCommit
  } copy_e;

  // controller to datapath
  typedef struct packed {
    logic  step;       // process accepted item
    logic  clr_wr;     // write zero to store at count
    logic  cp_rd;      // read source at count
    logic  cp_wr;      // write destination at delayed count
    copy_e dir;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic  start_copy;
    copy_e dir;
  } dp_stat_t;

  function automatic logic [7:0] crc7_byte(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ 8'h12) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/sdspi_ctrl.sv -----
// sdspi_ctrl: sequencer for clear pass, sector copies and handshakes
// depends on sdspi_pkg
module sdspi_ctrl
  import sdspi_pkg::*;
#(
  parameter int unsigned Sectors = SectorsDefault,
  localparam int unsigned StoreAw = $clog2(Sectors * BlkBytes) < 9 ? 9
                                    : $clog2(Sectors * BlkBytes)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              out_valid_q,
  input  logic              out_stall,
  input  dp_stat_t          stat,
  output ctrl_cmd_t         cmd,
  output logic [StoreAw:0]  cnt_o,
  output logic              out_set
);

  localparam logic [StoreAw:0] ClearLast = (StoreAw+1)'(Sectors * BlkBytes - 1);

  ctrl_e state_q, state_d;
  logic [StoreAw:0] cnt_q, cnt_d;
  copy_e dir_q, dir_d;

  assign cnt_o = cnt_q;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CsClear;
      cnt_q <= '0;
      dir_q <= CpNone;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      dir_q <= dir_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    dir_d = dir_q;
    cmd = '0;
    cmd.dir = dir_q;
    in_stall = 1'b1;
    out_set = 1'b0;
    unique case (state_q)
      CsClear: begin
        cmd.clr_wr = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == ClearLast) begin
          state_d = CsIdle;
          cnt_d = '0;
        end
      end
      CsIdle: begin
        in_stall = out_valid_q && out_stall;
        if (in_valid && !in_stall) begin
          cmd.step = 1'b1;
          if (stat.start_copy) begin
            state_d = CsCopy;
            dir_d = stat.dir;
            cnt_d = '0;
          end else begin
            out_set = 1'b1;
          end
        end
      end
      CsCopy: begin
        cmd.cp_rd = (cnt_q < (StoreAw+1)'(BlkBytes));
        cmd.cp_wr = (cnt_q != '0);
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (StoreAw+1)'(BlkBytes)) state_d = CsDone;
      end
      CsDone: begin
        out_set = 1'b1;
        dir_d = CpNone;
        state_d = CsIdle;
      end
      default: state_d = CsIdle;
    endcase
  end

  // no item taken during the clear pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == CsClear |-> in_stall) else $error("item during clear");
  // copy length bounded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == CsCopy |-> cnt_q <= (StoreAw+1)'(BlkBytes)) else $error("copy overrun");
  // copy always ends in done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == CsCopy && cnt_q == (StoreAw+1)'(BlkBytes) |=> state_q == CsDone)
    else $error("copy end lost");

endmodule

// ----- rtl/core/sdspi_dp.sv -----
// sdspi_dp: protocol registers, block buffer and card store
// depends on sdspi_pkg
module sdspi_dp
  import sdspi_pkg::*;
#(
  parameter int unsigned Sectors = SectorsDefault,
  localparam int unsigned StoreAw = $clog2(Sectors * BlkBytes) < 9 ? 9
                                    : $clog2(Sectors * BlkBytes),
  localparam int unsigned SecW = (StoreAw > 9) ? StoreAw - 9 : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       kind,
  input  logic [7:0]       wbyte,
  input  logic [1:0]       card_type,
  input  ctrl_cmd_t        cmd,
  input  logic [StoreAw:0] cnt,
  output dp_stat_t         stat,
  output logic [7:0]       rdata
);

  localparam logic [31:0] SecLim = 32'(Sectors);

  proto_e ps_q, ps_d;
  logic [9:0] inc_q, inc_d;
  logic signed [10:0] oi_q, oi_d;
  logic [7:0] cb_q [6];
  logic [7:0] cb_d [6];
  logic [7:0] crc_q, crc_d;
  logic app_q, app_d, hc_q, hc_d;
  logic [7:0] rb_q [6];
  logic [7:0] rb_d [6];
  logic [15:0] pos_q, pos_d;
  logic [7:0] rsel_q, rsel_d;
  logic buf_wr_en;
  logic [8:0] buf_wa;
  logic [7:0] buf_wd;
  logic [7:0] mem_buf [BlkBytes];
  logic [7:0] mem_store [Sectors * BlkBytes];
  logic [7:0] buf_rd_q, store_rd_q;
  logic [8:0] cp_wa_q;
  logic [8:0] buf_ra;
  logic buf_rsel_q;

  // combined item processing
  always_comb begin
    logic [7:0] op, b, crcv;
    logic [31:0] arg;
    logic [31:0] sec;
    logic ok, gb_buf;
    ps_d = ps_q; inc_d = inc_q; oi_d = oi_q; cb_d = cb_q; crc_d = crc_q;
    app_d = app_q; hc_d = hc_q; rb_d = rb_q; pos_d = pos_q; rsel_d = rsel_q;
    stat = '0;
    buf_wr_en = 1'b0; buf_wa = inc_q[8:0]; buf_wd = wbyte;
    b = wbyte; op = '0; crcv = '0; arg = '0; sec = '0; ok = 1'b0; gb_buf = 1'b0;
    buf_ra = oi_q[8:0];
    // give byte
    if (oi_q < 0) rsel_d = ByteIdle;
    else begin
      unique case (ps_q)
        PsR1, PsR3, PsR7, PsRdAck, PsRmAck, PsWrAck:
          rsel_d = (oi_q < 11'sd6) ? rb_q[oi_q[2:0]] : ByteIdle;
        PsRead, PsRmrd: begin rsel_d = '0; gb_buf = 1'b1; end
        default: rsel_d = ByteIdle;
      endcase
    end
    if (kind == KindStat) rsel_d = ByteStatus;
    else if (kind == KindWrite) rsel_d = '0;
    if (kind == KindWrite || kind == KindRead) begin
      // advance
      if (oi_d < 11'sd1023) oi_d = oi_q + 11'sd1;
      unique case (ps_q)
        PsIdle: oi_d = '0;
        PsR1: if (oi_d == 11'sd1) ps_d = PsIdle;
        PsR3: if (oi_d == 11'sd5) ps_d = PsIdle;
        PsR7: if (oi_d == 11'sd6) ps_d = PsIdle;
        PsRdAck: if (oi_d == 11'sd2) begin ps_d = PsRead; oi_d = '0; end
        PsRead: if (oi_d == 11'sd512) ps_d = PsIdle;
        PsRmAck: if (oi_d == 11'sd2) begin ps_d = PsRmrd; oi_d = '0; end
        PsRmrd: if (oi_d == 11'sd512) begin ps_d = PsRmnxt; oi_d = -11'sd6; end
        PsRmnxt: if (oi_d == '0) begin
          if (32'(pos_q) < SecLim) begin
            stat.start_copy = 1'b1; stat.dir = CpFetch;
            pos_d = pos_q + 16'd1; ps_d = PsRmAck;
          end else begin
            rb_d[0] = R1Crc; ps_d = PsR1;
          end
        end
        PsWrAck: if (oi_d == 11'sd1) ps_d = PsWrWait;
        default: ;
      endcase
    end
    if (kind == KindWrite) begin
      // take byte
      if (ps_d == PsWrWait) begin
        if (b == ByteToken) begin ps_d = PsWrite; inc_d = '0; end
      end else if (ps_d == PsWrite) begin
        if (inc_q < 10'd512) begin buf_wr_en = 1'b1; buf_wa = inc_q[8:0]; end
        inc_d = inc_q + 10'd1;
        if (inc_d == 10'd514) begin
          if (32'(pos_q) < SecLim) begin stat.start_copy = 1'b1; stat.dir = CpCommit; end
          rb_d[0] = R1Accept; oi_d = -11'sd2; ps_d = PsR1; inc_d = '0;
        end
      end else begin
        if (inc_q >= 10'd6) inc_d = '0;
        if (!(inc_d == '0 && b == ByteIdle)) begin
          cb_d[inc_d[2:0]] = b;
          if (inc_d < 10'd5) crc_d = crc7_byte(crc_q, b);
          inc_d = inc_d + 10'd1;
          if (inc_d == 10'd6) begin
            op = cb_d[0];
            if (!app_q) op = op & OpMask;
            app_d = 1'b0;
            arg = {cb_d[1], cb_d[2], cb_d[3], cb_d[4]};
            if (hc_q) begin sec = arg; ok = arg < SecLim; end
            else begin sec = arg >> 9; ok = (arg[8:0] == '0) && ((arg >> 9) < SecLim); end
            unique case (op)
              OpCmd0: begin rb_d[0] = 8'h01; oi_d = -11'sd2; ps_d = PsR1; end
              OpCmd8: begin
                oi_d = -11'sd2;
                if (card_type == CardSdv1) begin rb_d[0] = R1Accept; ps_d = PsR1; end
                else if ({1'b0, crc_d} + 9'd1 != {1'b0, cb_d[5]}) begin
                  rb_d[0] = R1Crc; ps_d = PsR1;
                end else begin
                  rb_d[0] = 8'h01; rb_d[1] = 8'h00; rb_d[2] = 8'h00;
                  rb_d[3] = 8'h01; rb_d[4] = cb_d[4];
                  for (int i = 0; i < 5; i++) crcv = crc7_byte(crcv, rb_d[i]);
                  rb_d[5] = crcv; ps_d = PsR7;
                end
              end
              OpCmd12: ps_d = PsIdle;
              OpCmd17, OpCmd18: begin
                rb_d[0] = R1Range; oi_d = -11'sd2; ps_d = PsR1;
                if (ok) begin
                  stat.start_copy = 1'b1; stat.dir = CpFetch;
                  pos_d = sec[15:0] + 16'd1;
                  rb_d[0] = 8'h00; rb_d[1] = ByteToken;
                  ps_d = (op == OpCmd17) ? PsRdAck : PsRmAck;
                end
              end
              OpCmd24: begin
                rb_d[0] = R1Range; oi_d = -11'sd2; ps_d = PsR1;
                if (ok) begin pos_d = sec[15:0]; rb_d[0] = 8'h00; ps_d = PsWrAck; end
              end
              OpCmd55: begin app_d = 1'b1; rb_d[0] = 8'h00; oi_d = -11'sd2; ps_d = PsR1; end
              OpCmd58: begin
                rb_d[0] = 8'h00; rb_d[1] = hc_q ? 8'h40 : 8'h00; rb_d[2] = ByteIdle;
                rb_d[3] = 8'h80; rb_d[4] = 8'h00; oi_d = -11'sd2; ps_d = PsR3;
              end
              OpAcmd41: begin
                if (card_type == CardSdhc && cb_d[1][6]) hc_d = 1'b1;
                rb_d[0] = 8'h00; oi_d = -11'sd2; ps_d = PsR1;
              end
              default: ;
            endcase
            inc_d = '0; crc_d = '0;
          end
        end
      end
    end
  end

  // protocol registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_q <= PsIdle; inc_q <= '0; oi_q <= '0; crc_q <= '0; app_q <= 1'b0;
      hc_q <= 1'b0; pos_q <= '0; rsel_q <= '0; buf_rsel_q <= 1'b0;
      for (int i = 0; i < 6; i++) begin cb_q[i] <= '0; rb_q[i] <= '0; end
    end else if (cmd.step) begin
      ps_q <= ps_d; inc_q <= inc_d; oi_q <= oi_d; crc_q <= crc_d; app_q <= app_d;
      hc_q <= hc_d; pos_q <= pos_d; rsel_q <= rsel_d; cb_q <= cb_d; rb_q <= rb_d;
      buf_rsel_q <= (kind == KindPeek || kind == KindRead) && (oi_q >= 0) &&
                    (ps_q == PsRead || ps_q == PsRmrd);
    end
  end

  assign rdata = buf_rsel_q ? buf_rd_q : rsel_q;

  // copy address pipe and store address
  logic [StoreAw-1:0] st_base;
  assign st_base = StoreAw'({pos_q[SecW-1:0], 9'd0});
  always_ff @(posedge clk_i) cp_wa_q <= cnt[8:0];

  // block buffer memory
  always_ff @(posedge clk_i) begin
    if (cmd.step && buf_wr_en) mem_buf[buf_wa] <= buf_wd;
    else if (cmd.cp_wr && cmd.dir == CpFetch) mem_buf[cp_wa_q] <= store_rd_q;
    if (cmd.cp_rd) buf_rd_q <= mem_buf[cnt[8:0]];
    else if (cmd.step) buf_rd_q <= mem_buf[buf_ra];
  end

  // card store memory; fetch uses sector base minus one after increment
  logic [StoreAw-1:0] rd_base;
  assign rd_base = StoreAw'({pos_q[SecW-1:0] - SecW'(1), 9'd0});
  always_ff @(posedge clk_i) begin
    if (cmd.clr_wr) mem_store[cnt[StoreAw-1:0]] <= '0;
    else if (cmd.cp_wr && cmd.dir == CpCommit)
      mem_store[st_base | StoreAw'(cp_wa_q)] <= buf_rd_q;
    store_rd_q <= mem_store[rd_base | StoreAw'(cnt[8:0])];
  end

  // protocol state checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ps_q == PsWrite |-> inc_q < 10'd514) else $error("write count overrun");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    oi_q <= 11'sd1023 && oi_q >= -11'sd6) else $error("pointer range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    inc_q <= 10'd513) else $error("count range");

endmodule

// ----- rtl/core/sd_card_spi_responder.sv -----
// sd_card_spi_responder: top level of the spi-mode card responder
// a sector fetch or commit copies the block one byte a cycle; no item is taken while it runs
// throughput: one item per cycle while no block copy runs and the output is not stalled
// reset: async active low; then a clear pass zeroes all SECTORS*512 bytes of the store
// depends on sdspi_pkg, sdspi_ctrl, sdspi_dp
module sd_card_spi_responder
  import sdspi_pkg::*;
#(
  parameter int unsigned Sectors = SectorsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] kind_i,
  input  logic [7:0] write_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] card_type_i
);

  localparam int unsigned StoreAw = $clog2(Sectors * BlkBytes) < 9 ? 9
                                    : $clog2(Sectors * BlkBytes);

  logic [1:0] card_type_q;
  logic out_valid_q;
  logic out_set;
  ctrl_cmd_t cmd;
  dp_stat_t stat;
  logic [StoreAw:0] cnt;

  assign cfg_ready_o = 1'b1;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) card_type_q <= CardSdhc;
    else if (cfg_valid_i) card_type_q <= card_type_i;
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (out_set) out_valid_q <= 1'b1;
    else if (!out_stall_i) out_valid_q <= 1'b0;
  end
  assign out_valid_o = out_valid_q;

  sdspi_ctrl #(.Sectors(Sectors)) u_ctrl (
    .clk_i, .rst_ni, .in_valid(in_valid_i), .in_stall(in_stall_o),
    .out_valid_q, .out_stall(out_stall_i), .stat, .cmd, .cnt_o(cnt), .out_set
  );

  sdspi_dp #(.Sectors(Sectors)) u_dp (
    .clk_i, .rst_ni, .kind(kind_i), .wbyte(write_byte_i), .card_type(card_type_q),
    .cmd, .cnt, .stat, .rdata(read_data_o)
  );

endmodule
